// ===== sv/ils_pkg.sv =====
// Shared types and codes for the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

	localparam int unsigned KIND_W   = 3;
	localparam int unsigned INDEX_W  = 5;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND    = 3'd0,
		KIND_PREPEND   = 3'd1,
		KIND_POP_BACK  = 3'd2,
		KIND_POP_FRONT = 3'd3,
		KIND_READ      = 3'd4,
		KIND_INSERT    = 3'd5,
		KIND_REMOVE    = 3'd6
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_SHIFT_UP   = 2'd1,
		CELL_SHIFT_DOWN = 2'd2
	} cell_op_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		cell_op_t op;
		logic     rd;
	} cell_cmd_t;

endpackage

// ===== sv/ils_cell.sv =====
// One slot of the list: holds an element and shifts to or from its neighbours.
`timescale 1ns / 1ps

module ils_cell
	import ils_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned IDX_W      = 4,
	parameter int unsigned POS        = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [IDX_W-1:0]      pos,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic [DATA_WIDTH-1:0] data_lo,
	input  logic [DATA_WIDTH-1:0] data_hi,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] rd_data
);

	localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_SHIFT_UP: begin
				// open a gap at pos and write wdata there: cells above take from below
				if (MY_POS > pos) begin
					data_q <= data_lo;
				end else if (MY_POS == pos) begin
					data_q <= wdata;
				end
			end
			CELL_SHIFT_DOWN: begin
				// close the slot at pos: cells at and above take from above
				if (MY_POS >= pos) begin
					data_q <= data_hi;
				end
			end
			default: begin
			end
		endcase
	end

	assign data    = data_q;
	assign rd_data = (cmd.rd && (MY_POS == pos)) ? data_q : '0;

endmodule

// ===== sv/indexed_list_store.sv =====
// Top level of the indexed list store: operation decode, fill count and result register.
`timescale 1ns / 1ps

// Indexed list store: an ordered list of up to CAPACITY elements in a row of
// slot cells, front at cell 0. Each input transaction (kind, index, value) is
// one operation: append, prepend, pop back, pop front, read, insert at index
// or remove at index. Each gives exactly one output transaction carrying
// status, read_value (zero unless a read succeeds) and count after the
// operation.
// The result shows on out_valid in the cycle after input acceptance.
// Throughput: one operation per cycle while in_stall is low; every cell shifts
// up, shifts down or holds in parallel in the accepting cycle.
// The result waits in an output register; while it is stalled and not taken,
// in_stall is raised and no further input is taken.
// Reset clears the fill count and the output valid; slot contents are left
// as they are and are never read before being written.
// Refused operations (full, out of range, empty) leave the list unchanged.

module indexed_list_store
	import ils_pkg::*;
#(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [INDEX_W-1:0]  index,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [VALUE_W-1:0]  read_value,
	output logic [COUNT_W-1:0]  count
);

	localparam int unsigned IDX_W  = $clog2(CAPACITY);
	localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W  = (FILL_W > INDEX_W) ? FILL_W : INDEX_W;
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CAPACITY);

	logic                  accept;
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     fill_d;
	status_t               status_d;
	cell_cmd_t             cmd;
	logic [IDX_W-1:0]      pos;
	logic [DATA_WIDTH-1:0] wdata;
	logic [CMP_W-1:0]      idx_c;
	logic [CMP_W-1:0]      fill_c;
	logic                  full;
	logic                  empty;
	logic [DATA_WIDTH-1:0] rd_any;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

	logic                out_valid_q;
	status_t             status_q;
	logic [VALUE_W-1:0]  read_value_q;
	logic [COUNT_W-1:0]  count_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign idx_c  = CMP_W'(index);
	assign fill_c = CMP_W'(fill_q);
	assign full   = (fill_q == FULL_FILL);
	assign empty  = (fill_q == '0);
	assign wdata  = DATA_WIDTH'(value);

	always_comb begin
		status_d = ST_OK;
		fill_d   = fill_q;
		cmd.op   = CELL_HOLD;
		cmd.rd   = 1'b0;
		pos      = IDX_W'(index);
		unique case (kind)
			KIND_APPEND: begin
				pos = IDX_W'(fill_q);
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op = CELL_SHIFT_UP;
					fill_d = fill_q + 1'b1;
				end
			end
			KIND_PREPEND: begin
				pos = '0;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op = CELL_SHIFT_UP;
					fill_d = fill_q + 1'b1;
				end
			end
			KIND_POP_BACK: begin
				pos = IDX_W'(fill_q - 1'b1);
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					cmd.op = CELL_SHIFT_DOWN;
					fill_d = fill_q - 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				pos = '0;
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					cmd.op = CELL_SHIFT_DOWN;
					fill_d = fill_q - 1'b1;
				end
			end
			KIND_READ: begin
				if (idx_c >= fill_c) begin
					status_d = ST_BOUNDS;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			KIND_INSERT: begin
				if (idx_c > fill_c) begin
					status_d = ST_BOUNDS;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op = CELL_SHIFT_UP;
					fill_d = fill_q + 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (idx_c >= fill_c) begin
					status_d = ST_BOUNDS;
				end else begin
					cmd.op = CELL_SHIFT_DOWN;
					fill_d = fill_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		// hold every cell unless a transaction is taken
		if (!accept) begin
			cmd.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lo;
		logic [DATA_WIDTH-1:0] hi;
		if (i == 0) begin : g_first
			assign lo = wdata;
		end else begin : g_mid_lo
			assign lo = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign hi = '0;
		end else begin : g_mid_hi
			assign hi = cell_data[i+1];
		end

		ils_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.IDX_W     (IDX_W),
			.POS       (i)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.pos    (pos),
			.wdata  (wdata),
			.data_lo(lo),
			.data_hi(hi),
			.data   (cell_data[i]),
			.rd_data(cell_rd[i])
		);
	end

	// at most one cell drives a non-zero read word
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			read_value_q <= VALUE_W'(rd_any);
			count_q      <= COUNT_W'(fill_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_FILL)
		else $error("fill count above capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q && (count_q == COUNT_W'(fill_q)))
		else $error("result missing or count out of step with fill");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (status_d != ST_OK) |=> $stable(fill_q))
		else $error("refused operation changed the fill count");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !accept)
		else $error("input taken while result stalled");
`endif

endmodule
